// ===== hdl/assert_macros.svh =====
// shared assertion macros for the block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted while reset is high
`define ASSERT_SAME(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication, muted while reset is high
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

// next-cycle implication that also holds across reset
`define ASSERT_ALWAYS_NEXT(label, clk, lhs, rhs, msg) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) else $error(msg);

`endif

// ===== hdl/ppt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ppt_pkg;
   localparam int COORD_BITS_DEF     = 16;
   localparam int COEF_FRAC_BITS_DEF = 16;
   localparam int PERSP_FRAC_BITS    = 30;
   localparam int ACC_BITS           = 64;
   localparam int COEF_BITS          = 32;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 64;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_XX         = 3'd0,
      CSR_COEF_XY         = 3'd1,
      CSR_COEF_XT         = 3'd2,
      CSR_COEF_YX         = 3'd3,
      CSR_COEF_YY         = 3'd4,
      CSR_COEF_YT         = 3'd5,
      CSR_COEF_PERSP_PAIR = 3'd6,
      CSR_COEF_WT         = 3'd7
   } csr_index_type;
endpackage
`default_nettype wire

// ===== hdl/projective_point_transform_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                               direction  transfer when
// req       req_valid req_stall req_src_u/v     in         req_valid && !req_stall
// rsp       rsp_valid rsp_stall rsp_dst_*, flags out        rsp_valid && !rsp_stall
// csr       csr_write csr_index csr_wdata       in         csr_write
//
// one point per cycle sustained while rsp_stall stays low; the restoring divider
// makes one quotient bit per stage, two lanes sharing w
// every stage has its own valid bit and moves up into bubbles, so the front
// keeps taking points while a result waits on rsp_stall until the pipe is full
// synchronous reset empties the pipe and loads the identity matrix
module projective_point_transform_unit import ppt_pkg::*; #(
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_src_u,
   input  logic signed [COORD_BITS-1:0] req_src_v,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_dst_x,
   output logic signed [COORD_BITS-1:0] rsp_dst_y,
   output logic                         rsp_zero_denominator,
   output logic                         rsp_saturated,
   input  logic                         csr_write,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata
);
   // quotient bits kept: one beyond the output range, anything larger saturates
   localparam int K     = COORD_BITS + 1;
   localparam int SHIFT = PERSP_FRAC_BITS - COEF_FRAC_BITS;
   localparam int PW    = COEF_BITS + COORD_BITS;
   localparam int DW    = ACC_BITS + K;
   localparam int QW    = COORD_BITS + 3;

   typedef struct packed {
      logic [ACC_BITS-1:0] rem_x;
      logic [ACC_BITS-1:0] rem_y;
      logic [ACC_BITS-1:0] md;
      logic [K-1:0]        q_x;
      logic [K-1:0]        q_y;
      logic                neg_x;
      logic                neg_y;
      logic                ov_x;
      logic                ov_y;
      logic                zero;
   } div_type;

   // coefficient registers
   logic signed [COEF_BITS-1:0] coef_xx_ff, coef_xy_ff, coef_xt_ff;
   logic signed [COEF_BITS-1:0] coef_yx_ff, coef_yy_ff, coef_yt_ff, coef_wt_ff;
   logic [CSR_DATA_BITS-1:0]    coef_persp_ff;
   logic signed [COEF_BITS-1:0] h31, h32;

   assign h31 = signed'(coef_persp_ff[COEF_BITS-1:0]);
   assign h32 = signed'(coef_persp_ff[2*COEF_BITS-1:COEF_BITS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff    <= COEF_BITS'(1) <<< COEF_FRAC_BITS;
         coef_xy_ff    <= '0;
         coef_xt_ff    <= '0;
         coef_yx_ff    <= '0;
         coef_yy_ff    <= COEF_BITS'(1) <<< COEF_FRAC_BITS;
         coef_yt_ff    <= '0;
         coef_persp_ff <= '0;
         coef_wt_ff    <= COEF_BITS'(1) <<< COEF_FRAC_BITS;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_XX:         coef_xx_ff    <= signed'(csr_wdata[COEF_BITS-1:0]);
            CSR_COEF_XY:         coef_xy_ff    <= signed'(csr_wdata[COEF_BITS-1:0]);
            CSR_COEF_XT:         coef_xt_ff    <= signed'(csr_wdata[COEF_BITS-1:0]);
            CSR_COEF_YX:         coef_yx_ff    <= signed'(csr_wdata[COEF_BITS-1:0]);
            CSR_COEF_YY:         coef_yy_ff    <= signed'(csr_wdata[COEF_BITS-1:0]);
            CSR_COEF_YT:         coef_yt_ff    <= signed'(csr_wdata[COEF_BITS-1:0]);
            CSR_COEF_PERSP_PAIR: coef_persp_ff <= csr_wdata;
            CSR_COEF_WT:         coef_wt_ff    <= signed'(csr_wdata[COEF_BITS-1:0]);
            default: ;
         endcase
      end
   end

   // ready chain, back to front
   logic s0_ready, s1_ready, s2_ready, out_ready;
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic    div_valid_ff [0:K];
   logic    div_ready    [0:K];
   div_type div_ff       [0:K];

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || div_ready[0];
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_stall = !s0_ready;

   // stage 0: six products
   logic signed [PW-1:0] p_xu_ff, p_xv_ff, p_yu_ff, p_yv_ff, p_wu_ff, p_wv_ff;
   logic signed [PW-1:0] p_xu_in, p_xv_in, p_yu_in, p_yv_in, p_wu_in, p_wv_in;

   always_comb begin
      p_xu_in = PW'(coef_xx_ff) * PW'(req_src_u);
      p_xv_in = PW'(coef_xy_ff) * PW'(req_src_v);
      p_yu_in = PW'(coef_yx_ff) * PW'(req_src_u);
      p_yv_in = PW'(coef_yy_ff) * PW'(req_src_v);
      p_wu_in = PW'(h31) * PW'(req_src_u);
      p_wv_in = PW'(h32) * PW'(req_src_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
      if (s0_ready && req_valid) begin
         p_xu_ff <= p_xu_in;
         p_xv_ff <= p_xv_in;
         p_yu_ff <= p_yu_in;
         p_yv_ff <= p_yv_in;
         p_wu_ff <= p_wu_in;
         p_wv_ff <= p_wv_in;
      end
   end

   // stage 1: numerators aligned to the denominator's 30 fraction bits, 64-bit wrap
   logic signed [ACC_BITS-1:0] nx_ff, ny_ff, w_ff;
   logic signed [ACC_BITS-1:0] nx_in, ny_in, w_in;

   always_comb begin
      nx_in = (ACC_BITS'(p_xu_ff) + ACC_BITS'(p_xv_ff) + ACC_BITS'(coef_xt_ff)) <<< SHIFT;
      ny_in = (ACC_BITS'(p_yu_ff) + ACC_BITS'(p_yv_ff) + ACC_BITS'(coef_yt_ff)) <<< SHIFT;
      w_in  = ACC_BITS'(p_wu_ff) + ACC_BITS'(p_wv_ff) + (ACC_BITS'(coef_wt_ff) <<< SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (s1_ready && s0_valid_ff) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         w_ff  <= w_in;
      end
   end

   // stage 2: sign and magnitude
   logic [ACC_BITS-1:0] mnx_ff, mny_ff, md_ff;
   logic                negx_ff, negy_ff, zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         mnx_ff  <= nx_ff[ACC_BITS-1] ? ACC_BITS'(0) - nx_ff : nx_ff;
         mny_ff  <= ny_ff[ACC_BITS-1] ? ACC_BITS'(0) - ny_ff : ny_ff;
         md_ff   <= w_ff[ACC_BITS-1] ? ACC_BITS'(0) - w_ff : w_ff;
         negx_ff <= nx_ff[ACC_BITS-1] ^ w_ff[ACC_BITS-1];
         negy_ff <= ny_ff[ACC_BITS-1] ^ w_ff[ACC_BITS-1];
         zero_ff <= (w_ff == '0);
      end
   end

   // divider entry: quotient too large for K bits is flagged here
   div_type div0_in;
   logic [DW-1:0] md_top;

   always_comb begin
      md_top        = {md_ff, {K{1'b0}}};
      div0_in.rem_x = mnx_ff;
      div0_in.rem_y = mny_ff;
      div0_in.md    = md_ff;
      div0_in.q_x   = '0;
      div0_in.q_y   = '0;
      div0_in.neg_x = negx_ff;
      div0_in.neg_y = negy_ff;
      div0_in.ov_x  = DW'(mnx_ff) >= md_top;
      div0_in.ov_y  = DW'(mny_ff) >= md_top;
      div0_in.zero  = zero_ff;
   end

   assign div_ready[0] = !div_valid_ff[0] || div_ready[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (div_ready[0]) begin
         div_valid_ff[0] <= s2_valid_ff;
      end
      if (div_ready[0] && s2_valid_ff) begin
         div_ff[0] <= div0_in;
      end
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar d = 1; d <= K; d++) begin : g_div
      localparam int BIT = K - d;
      div_type       step_in;
      logic [DW-1:0] trial;

      if (d == K) begin : g_last
         assign div_ready[d] = !div_valid_ff[d] || out_ready;
      end else begin : g_mid
         assign div_ready[d] = !div_valid_ff[d] || div_ready[d+1];
      end

      always_comb begin
         step_in = div_ff[d-1];
         trial   = DW'(div_ff[d-1].md) << BIT;
         if (DW'(div_ff[d-1].rem_x) >= trial) begin
            step_in.rem_x    = div_ff[d-1].rem_x - trial[ACC_BITS-1:0];
            step_in.q_x[BIT] = 1'b1;
         end
         if (DW'(div_ff[d-1].rem_y) >= trial) begin
            step_in.rem_y    = div_ff[d-1].rem_y - trial[ACC_BITS-1:0];
            step_in.q_y[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[d] <= 1'b0;
         end else if (div_ready[d]) begin
            div_valid_ff[d] <= div_valid_ff[d-1];
         end
         if (div_ready[d] && div_valid_ff[d-1]) begin
            div_ff[d] <= step_in;
         end
      end
   end

   // signed floor quotient, round half up, add one when negative and no tie, clamp
   // result is {saturated, coordinate}
   function automatic logic [COORD_BITS:0] finish(input logic [K-1:0] qm,
                                                  input logic [ACC_BITS-1:0] r,
                                                  input logic [ACC_BITS-1:0] md,
                                                  input logic neg,
                                                  input logic ov);
      logic signed [QW-1:0] q;
      logic signed [QW-1:0] lim_hi;
      logic signed [QW-1:0] lim_lo;
      logic [ACC_BITS:0]    r2;
      logic                 lt, eq, nz, up;
      lim_hi = {4'b0000, {(COORD_BITS-1){1'b1}}};
      lim_lo = {4'b1111, {(COORD_BITS-1){1'b0}}};
      r2     = {r, 1'b0};
      lt     = r2 < {1'b0, md};
      eq     = r2 == {1'b0, md};
      nz     = r != '0;
      if (neg) begin
         q  = QW'(0) - QW'(qm) - QW'(nz);
         up = nz ? (lt || eq) : !lt;
      end else begin
         q  = QW'(qm);
         up = !lt;
      end
      q = q + QW'(up);
      if (q < 0 && !eq) q = q + QW'(1);
      if (ov) begin
         finish = {1'b1, neg ? lim_lo[COORD_BITS-1:0] : lim_hi[COORD_BITS-1:0]};
      end else if (q > lim_hi) begin
         finish = {1'b1, lim_hi[COORD_BITS-1:0]};
      end else if (q < lim_lo) begin
         finish = {1'b1, lim_lo[COORD_BITS-1:0]};
      end else begin
         finish = {1'b0, q[COORD_BITS-1:0]};
      end
   endfunction

   // output stage
   logic [COORD_BITS:0]          fin_x, fin_y;
   logic signed [COORD_BITS-1:0] dst_x_ff, dst_y_ff;
   logic                         zero_out_ff, sat_out_ff;

   assign fin_x = finish(div_ff[K].q_x, div_ff[K].rem_x, div_ff[K].md,
                         div_ff[K].neg_x, div_ff[K].ov_x);
   assign fin_y = finish(div_ff[K].q_y, div_ff[K].rem_y, div_ff[K].md,
                         div_ff[K].neg_y, div_ff[K].ov_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_valid_ff[K];
      end
      if (out_ready && div_valid_ff[K]) begin
         if (div_ff[K].zero) begin
            // degenerate w: zero point, flag only the denominator
            dst_x_ff    <= '0;
            dst_y_ff    <= '0;
            zero_out_ff <= 1'b1;
            sat_out_ff  <= 1'b0;
         end else begin
            dst_x_ff    <= signed'(fin_x[COORD_BITS-1:0]);
            dst_y_ff    <= signed'(fin_y[COORD_BITS-1:0]);
            zero_out_ff <= 1'b0;
            sat_out_ff  <= fin_x[COORD_BITS] | fin_y[COORD_BITS];
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_dst_x            = dst_x_ff;
   assign rsp_dst_y            = dst_y_ff;
   assign rsp_zero_denominator = zero_out_ff;
   assign rsp_saturated        = sat_out_ff;
endmodule
`default_nettype wire

// ===== hdl/ppt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ppt_checker import ppt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic signed [COORD_BITS-1:0] req_src_u,
   input logic signed [COORD_BITS-1:0] req_src_v,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [COORD_BITS-1:0] rsp_dst_x,
   input logic signed [COORD_BITS-1:0] rsp_dst_y,
   input logic                         rsp_zero_denominator,
   input logic                         rsp_saturated,
   input logic                         csr_write,
   input logic [CSR_INDEX_BITS-1:0]    csr_index,
   input logic [CSR_DATA_BITS-1:0]     csr_wdata
);
   logic unused_inputs;
   assign unused_inputs = req_valid ^ (^req_src_u) ^ (^req_src_v) ^ csr_write
                          ^ (^csr_index) ^ (^csr_wdata);

   // a zero denominator gives the origin and never a clamp
   `ASSERT_SAME(a_zero_den_clean, clock, reset, rsp_valid && rsp_zero_denominator,
      rsp_dst_x == '0 && rsp_dst_y == '0 && !rsp_saturated, "zero denominator result not clean")
   // an empty output side means the pipe can always take a point
   `ASSERT_SAME(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall,
      "input stalled while output idle")
   // a held result keeps its value
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_dst_x) && $stable(rsp_dst_y)
      && $stable(rsp_saturated) && $stable(rsp_zero_denominator), "stalled result changed")
   // reset empties the pipe
   `ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")
endmodule

bind projective_point_transform_unit ppt_checker #(.COORD_BITS(COORD_BITS)) u_ppt_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .req_src_u(req_src_u), .req_src_v(req_src_v),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_dst_x(rsp_dst_x), .rsp_dst_y(rsp_dst_y),
   .rsp_zero_denominator(rsp_zero_denominator), .rsp_saturated(rsp_saturated),
   .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
);
`default_nettype wire
